// ----- design/cordic_sine_fixed_core_assert.svh -----
// ----------------------------------------------------------------------------
// CORDIC sine core assertion macros
// Concurrent assertion wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_FIXED_CORE_ASSERT_SVH
`define CORDIC_SINE_FIXED_CORE_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define CSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed cycle delay.
`define CSF_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- design/csf_pkg.sv -----
// ----------------------------------------------------------------------------
// CORDIC sine core package
// Widths, angle constants, arctangent and gain words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  localparam int MaxIter     = 16;
  localparam int AngleW      = 12;
  localparam int SineW       = 10;
  localparam int IterW       = 5;
  localparam int CoordW      = 12;
  localparam int BetaW       = 12;
  localparam int GainW       = 8;
  localparam int ProdW       = CoordW + GainW + 1;
  localparam int GainShift   = 8;
  localparam int HalfTurn    = 1024;
  localparam int QuarterTurn = 512;
  localparam int UnitX       = 256;
  localparam int IterReset   = 9;
  localparam int SineMax     = 511;
  localparam int SineMin     = -512;
  localparam int Latency     = MaxIter + 3;

  function automatic logic signed [BetaW-1:0] atan_word(input int step);
    logic signed [BetaW-1:0] w;
    case (step)
      0:       w = BetaW'(256);
      1:       w = BetaW'(151);
      2:       w = BetaW'(80);
      3:       w = BetaW'(41);
      4:       w = BetaW'(20);
      5:       w = BetaW'(10);
      6:       w = BetaW'(5);
      7:       w = BetaW'(3);
      8:       w = BetaW'(1);
      9:       w = BetaW'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [GainW-1:0] gain_word(input logic [IterW-1:0] n);
    logic [GainW-1:0] g;
    case (n)
      IterW'(0): g = GainW'(181);
      IterW'(1): g = GainW'(162);
      IterW'(2): g = GainW'(157);
      IterW'(3): g = GainW'(156);
      IterW'(4): g = GainW'(156);
      default:   g = GainW'(155);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- design/cordic_sine_fixed_core.sv -----
// ----------------------------------------------------------------------------
// CORDIC sine core
// channel   ports                                   direction
// input     start, busy, in_angle                   command in
// result    out_strobe, out_sine                    strobe out, no back-pressure
// config    cfg_valid, cfg_ready, cfg_iterations    write in
//
// One angle per cycle; after acceptance each transaction passes through
// one fold stage, one stage per rotation step (16), one gain multiply
// stage and the output register, which holds its sine. busy stays low.
// Reset clears all valid bits and loads 9 rotation steps.
// cfg_ready is high only while no transaction is in flight and start is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cordic_sine_fixed_core
  import csf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [AngleW-1:0] in_angle,
  output logic                     out_strobe,
  output logic signed [SineW-1:0]  out_sine,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IterW-1:0]         cfg_iterations
);

  logic [IterW-1:0] iter_r;

  logic [MaxIter:0]          vld_r;
  logic                      neg_r [0:MaxIter];
  logic signed [CoordW-1:0]  x_r   [0:MaxIter];
  logic signed [CoordW-1:0]  y_r   [0:MaxIter];
  logic signed [BetaW-1:0]   z_r   [0:MaxIter];

  logic                      mul_vld_r;
  logic                      mul_neg_r;
  logic signed [ProdW-1:0]   prod_r;
  logic signed [ProdW-1:0]   prod_nxt;

  logic                      out_strobe_r;
  logic signed [SineW-1:0]   out_sine_r;
  logic signed [SineW-1:0]   out_sine_nxt;

  logic                      accept;
  logic signed [AngleW:0]    b0, b1, b2;
  logic                      f1, f2;
  logic signed [ProdW-1:0]   sh;
  logic signed [ProdW-1:0]   res;
  logic                      fold_ok;

  assign accept    = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = !(|vld_r) && !mul_vld_r && !out_strobe_r && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= IterW'(IterReset);
    end else if (cfg_valid && cfg_ready) begin
      iter_r <= cfg_iterations;
    end
  end

  // fold into -512..512, at most two half-turn corrections
  always_comb begin
    b0 = (AngleW+1)'(in_angle);
    f1 = (b0 < -QuarterTurn) || (b0 > QuarterTurn);
    if (b0 < -QuarterTurn) begin
      b1 = b0 + (AngleW+1)'(HalfTurn);
    end else if (b0 > QuarterTurn) begin
      b1 = b0 - (AngleW+1)'(HalfTurn);
    end else begin
      b1 = b0;
    end
    f2 = (b1 < -QuarterTurn) || (b1 > QuarterTurn);
    if (b1 < -QuarterTurn) begin
      b2 = b1 + (AngleW+1)'(HalfTurn);
    end else if (b1 > QuarterTurn) begin
      b2 = b1 - (AngleW+1)'(HalfTurn);
    end else begin
      b2 = b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    neg_r[0] <= f1 ^ f2;
    x_r[0]   <= CoordW'(UnitX);
    y_r[0]   <= '0;
    z_r[0]   <= BetaW'(b2);
  end

  for (genvar k = 0; k < MaxIter; k++) begin : g_step
    logic                     act;
    logic                     sgn;
    logic signed [CoordW-1:0] tx, ty;
    logic signed [CoordW-1:0] x_nxt, y_nxt;
    logic signed [BetaW-1:0]  z_nxt;

    always_comb begin
      act = IterW'(k) < iter_r;
      sgn = z_r[k][BetaW-1];
      tx  = sgn ? -x_r[k] : x_r[k];
      ty  = sgn ? -y_r[k] : y_r[k];
      if (act) begin
        x_nxt = x_r[k] - (ty >>> k);
        y_nxt = y_r[k] + (tx >>> k);
        z_nxt = sgn ? (z_r[k] + atan_word(k)) : (z_r[k] - atan_word(k));
      end else begin
        x_nxt = x_r[k];
        y_nxt = y_r[k];
        z_nxt = z_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[k+1] <= neg_r[k];
      x_r[k+1]   <= x_nxt;
      y_r[k+1]   <= y_nxt;
      z_r[k+1]   <= z_nxt;
    end
  end

  assign prod_nxt = ProdW'(y_r[MaxIter]) * $signed(ProdW'({1'b0, gain_word(iter_r)}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      mul_vld_r    <= vld_r[MaxIter];
      out_strobe_r <= mul_vld_r;
    end
  end

  // scale, apply fold sign, clamp
  always_comb begin
    sh  = prod_r >>> GainShift;
    res = mul_neg_r ? -sh : sh;
    if (res > SineMax) begin
      out_sine_nxt = SineW'(SineMax);
    end else if (res < SineMin) begin
      out_sine_nxt = SineW'(SineMin);
    end else begin
      out_sine_nxt = SineW'(res);
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    mul_neg_r  <= neg_r[MaxIter];
    out_sine_r <= out_sine_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_sine   = out_sine_r;

  assign fold_ok = (z_r[0] >= -QuarterTurn) && (z_r[0] <= QuarterTurn);

`include "cordic_sine_fixed_core_assert.svh"

  `CSF_ASSERT_DELAY(a_latency, clk, rst_n, accept, Latency, out_strobe, "result strobe missing")
  `CSF_ASSERT_IMPLY(a_fold_range, clk, rst_n, vld_r[0], fold_ok, "folded angle out of range")
  `CSF_ASSERT_IMPLY(a_zero_steps, clk, rst_n, out_strobe && iter_r == '0, out_sine == '0, "zero steps")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// CORDIC sine core testbench
// Drives angles through the command port and checks each sine against a
// local fixed-point CORDIC predictor or a fixed row's value. A directed
// table covers fold limits, angle and iteration-count extremes. Random
// phases of varied iteration counts follow, one without random start gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import csf_pkg::*;

  typedef struct packed {
    logic [IterW-1:0]         iters;
    logic signed [AngleW-1:0] angle;
    logic                     fixed;
    logic signed [SineW-1:0]  sine;
  } angle_row_t;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic [IterW-1:0]         iters;
    logic signed [SineW-1:0]  sine;
  } pending_sine_t;

  localparam int ArcTanCount = 10;
  localparam int ArcTan [ArcTanCount] = '{256, 151, 80, 41, 20, 10, 5, 3, 1, 1};
  localparam int GainTab [6] = '{181, 162, 157, 156, 156, 155};
  localparam int DirectedRows = 20;
  localparam int RandomPhases = 9;
  localparam int PhaseItems = 50;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [AngleW-1:0] in_angle;
  logic                     out_strobe;
  logic signed [SineW-1:0]  out_sine;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IterW-1:0]         cfg_iterations;

  logic [IterW-1:0] cur_iters;
  pending_sine_t    sine_queue[$];
  int               mismatches = 0;
  bit               steady = 1'b0;

  angle_row_t directed_rows [DirectedRows] = '{
    '{IterW'(9),  12'sd0,     1'b0, 10'sd0},
    '{IterW'(9),  12'sd2047,  1'b0, 10'sd0},
    '{IterW'(9),  -12'sd2048, 1'b0, 10'sd0},
    '{IterW'(9),  12'sd512,   1'b0, 10'sd0},
    '{IterW'(9),  -12'sd512,  1'b0, 10'sd0},
    '{IterW'(9),  12'sd513,   1'b0, 10'sd0},
    '{IterW'(9),  -12'sd513,  1'b0, 10'sd0},
    '{IterW'(9),  12'sd1024,  1'b0, 10'sd0},
    '{IterW'(9),  -12'sd1024, 1'b0, 10'sd0},
    '{IterW'(9),  12'sd1536,  1'b0, 10'sd0},
    '{IterW'(9),  -12'sd1537, 1'b0, 10'sd0},
    '{IterW'(9),  12'sd256,   1'b0, 10'sd0},
    '{IterW'(0),  12'sd300,   1'b1, 10'sd0},
    '{IterW'(0),  -12'sd2048, 1'b1, 10'sd0},
    '{IterW'(31), 12'sd100,   1'b0, 10'sd0},
    '{IterW'(31), -12'sd700,  1'b0, 10'sd0},
    '{IterW'(16), 12'sd2047,  1'b0, 10'sd0},
    '{IterW'(16), 12'sd512,   1'b0, 10'sd0},
    '{IterW'(1),  -12'sd1,    1'b0, 10'sd0},
    '{IterW'(17), 12'sd400,   1'b0, 10'sd0}
  };

  int phase_iters [RandomPhases] = '{9, 16, 0, 31, 1, -1, 5, -1, 12};

  cordic_sine_fixed_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_angle       (in_angle),
    .out_strobe     (out_strobe),
    .out_sine       (out_sine),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_iterations (cfg_iterations)
  );

  always #2 clk = ~clk;

  function automatic logic signed [SineW-1:0] cordic_sine(
    input logic signed [AngleW-1:0] angle,
    input logic [IterW-1:0]         iters
  );
    int     beta;
    int     n;
    int     a;
    bit     flip;
    bit     neg;
    longint x;
    longint y;
    longint tx;
    longint ty;
    longint nx;
    longint r;
    beta = angle;
    flip = 1'b0;
    while (beta < -QuarterTurn || beta > QuarterTurn) begin
      beta += (beta < 0) ? HalfTurn : -HalfTurn;
      flip = !flip;
    end
    n = (iters > MaxIter) ? MaxIter : int'(iters);
    x = UnitX;
    y = 0;
    for (int j = 0; j < n; j++) begin
      neg = beta < 0;
      ty = neg ? -y : y;
      tx = neg ? -x : x;
      a = (j < ArcTanCount) ? ArcTan[j] : 0;
      nx = x - (ty >>> j);
      y = y + (tx >>> j);
      x = nx;
      beta -= neg ? -a : a;
    end
    r = (y * GainTab[(n < 5) ? n : 5]) >>> GainShift;
    if (flip) r = -r;
    if (r > SineMax) r = SineMax;
    if (r < SineMin) r = SineMin;
    return SineW'(r);
  endfunction

  function automatic logic signed [AngleW-1:0] pick_angle();
    int v;
    case ($urandom_range(3))
      0, 1: v = $urandom_range(4095);
      2: begin
        v = $urandom_range(1, 4) * QuarterTurn + $urandom_range(4) - 2;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom_range(127) - 64;
    endcase
    return AngleW'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] sine mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_angle(input logic signed [AngleW-1:0] angle, input bit fixed,
                            input logic signed [SineW-1:0] fixed_sine);
    bit taken;
    pending_sine_t p;
    while (!steady && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_angle <= angle;
    p.angle = angle;
    p.iters = cur_iters;
    p.sine = fixed ? fixed_sine : cordic_sine(angle, cur_iters);
    do begin
      @(negedge clk);
      taken = !busy;
      if (taken) sine_queue.push_back(p);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_iterations(input logic [IterW-1:0] value);
    bit taken;
    start <= 1'b0;
    while (sine_queue.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_iterations <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    cur_iters = value;
  endtask

  always @(posedge clk) begin
    pending_sine_t p;
    if (rst_n && out_strobe) begin
      if (sine_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_sine));
      end else begin
        p = sine_queue.pop_front();
        if (out_sine !== p.sine)
          report_mismatch($sformatf("angle %0d iters %0d: got %0d, want %0d",
                                    p.angle, p.iters, out_sine, p.sine));
      end
    end
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int v;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_angle <= '0;
    cfg_valid <= 1'b0;
    cfg_iterations <= '0;
    cur_iters = IterW'(IterReset);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].iters != cur_iters) write_iterations(directed_rows[i].iters);
      send_angle(directed_rows[i].angle, directed_rows[i].fixed, directed_rows[i].sine);
    end

    foreach (phase_iters[k]) begin
      v = (phase_iters[k] < 0) ? $urandom_range(31) : phase_iters[k];
      write_iterations(IterW'(v));
      steady = (k == 1);
      repeat (PhaseItems) send_angle(pick_angle(), 1'b0, '0);
    end

    start <= 1'b0;
    while (sine_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0 && sine_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
